### rtl/per_source_rate_limit_table_unit_macros.svh
// ----------------------------------------------------------------------------
// per_source_rate_limit_table_unit_macros
// assertion macros shared by the rate limiter; they expect clk and rst_n
// ----------------------------------------------------------------------------
`ifndef PER_SOURCE_RATE_LIMIT_TABLE_UNIT_MACROS_SVH
`define PER_SOURCE_RATE_LIMIT_TABLE_UNIT_MACROS_SVH

// same-cycle implication
`define PSRL_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PSRL_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/psrl_pkg.sv
// ----------------------------------------------------------------------------
// psrl_pkg
// types and constants of the per-source rate limiter
// ----------------------------------------------------------------------------
`default_nettype none

package psrl_pkg;

    localparam int ADDR_W  = 32;
    localparam int TIME_W  = 32;
    localparam int CNT_W   = 8;
    localparam int WIN_W   = 16;
    localparam int SLOT_W  = 5;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic [CNT_W-1:0] CNT_MAX    = '1;
    localparam logic [WIN_W-1:0] WINDOW_RST = 16'd10;
    localparam logic [CNT_W-1:0] MAX_RST    = 8'd3;

    typedef enum logic [0:0] {
        REG_WINDOW = 1'b0,
        REG_MAX    = 1'b1
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_READ,
        ST_WAIT
    } state_t;

    typedef struct packed {
        logic capture;
        logic scan_rd;
        logic sel_rd;
        logic commit;
    } cmd_t;

    typedef struct packed {
        logic scan_last;
        logic match;
        logic out_busy;
    } sts_t;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [TIME_W-1:0] start;
        logic [CNT_W-1:0]  count;
    } slot_t;

endpackage

`default_nettype wire

### rtl/psrl_if.sv
// ----------------------------------------------------------------------------
// psrl_if
// request and response channels of the rate limiter
// ----------------------------------------------------------------------------
`default_nettype none

interface psrl_req_if;
    import psrl_pkg::*;

    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] source_address;
    logic [TIME_W-1:0] now_seconds;

    modport source (output valid, output source_address, output now_seconds, input ready);
    modport sink   (input valid, input source_address, input now_seconds, output ready);
endinterface

interface psrl_rsp_if;
    import psrl_pkg::*;

    logic              valid;
    logic              ready;
    logic              throttled;
    logic [SLOT_W-1:0] slot_used;

    modport source (output valid, output throttled, output slot_used, input ready);
    modport sink   (input valid, input throttled, input slot_used, output ready);
endinterface

`default_nettype wire

### rtl/psrl_regs.sv
// ----------------------------------------------------------------------------
// psrl_regs
// apb configuration registers: window length and check limit
// ----------------------------------------------------------------------------
`default_nettype none

module psrl_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [psrl_pkg::PADDR_W-1:0]  paddr,
    input  logic [psrl_pkg::PDATA_W-1:0]  pwdata,
    output logic [psrl_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready,
    output logic [psrl_pkg::WIN_W-1:0]    window_seconds,
    output logic [psrl_pkg::CNT_W-1:0]    max_checks
);
    import psrl_pkg::*;

    logic [WIN_W-1:0] window_reg;
    logic [CNT_W-1:0] max_reg;
    logic             wr_en;
    reg_idx_t         idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = reg_idx_t'(paddr[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= WINDOW_RST;
            max_reg    <= MAX_RST;
        end
        else if (wr_en)
        begin
            case (idx)
                REG_WINDOW: window_reg <= pwdata[WIN_W-1:0];
                REG_MAX:    max_reg    <= pwdata[CNT_W-1:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_WINDOW: prdata = PDATA_W'(window_reg);
            REG_MAX:    prdata = PDATA_W'(max_reg);
            default:    prdata = '0;
        endcase
    end

    assign window_seconds = window_reg;
    assign max_checks     = max_reg;

endmodule

`default_nettype wire

### rtl/psrl_ctrl.sv
// ----------------------------------------------------------------------------
// psrl_ctrl
// sequencer: capture, table scan, slot read, update and result hand-off
// ----------------------------------------------------------------------------
`default_nettype none

module psrl_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  psrl_pkg::sts_t sts,
    output psrl_pkg::cmd_t cmd
);
    import psrl_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_ready  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.scan_rd = 1'b1;
                if (sts.match)
                begin
                    state_next = ST_READ;
                end
                else if (sts.scan_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_READ;
            end
            ST_READ:
            begin
                cmd.sel_rd = 1'b1;
                state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (!sts.out_busy)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

### rtl/psrl_dp.sv
// ----------------------------------------------------------------------------
// psrl_dp
// slot table, scan trackers, slot update and result register
// ----------------------------------------------------------------------------
`default_nettype none

module psrl_dp #(
    parameter int SLOTS = 24
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  psrl_pkg::cmd_t               cmd,
    output psrl_pkg::sts_t               sts,
    input  logic [psrl_pkg::ADDR_W-1:0]  source_address,
    input  logic [psrl_pkg::TIME_W-1:0]  now_seconds,
    input  logic [psrl_pkg::WIN_W-1:0]   window_seconds,
    input  logic [psrl_pkg::CNT_W-1:0]   max_checks,
    input  logic                         rsp_ready,
    output logic                         rsp_valid,
    output logic                         throttled,
    output logic [psrl_pkg::SLOT_W-1:0]  slot_used
);
    import psrl_pkg::*;

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);

    slot_t             mem [SLOTS];
    slot_t             q_reg;
    slot_t             wr_slot;

    logic [ADDR_W-1:0] addr_reg;
    logic [TIME_W-1:0] now_reg;
    logic [IW-1:0]     scan_idx_reg;
    logic [IW-1:0]     cmp_idx_reg;
    logic              cmp_vld_reg;
    logic [SLOTS-1:0]  vld_reg;
    logic              match_reg;
    logic [IW-1:0]     match_idx_reg;
    logic              have_empty_reg;
    logic [IW-1:0]     empty_idx_reg;
    logic              have_min_reg;
    logic [TIME_W-1:0] min_start_reg;
    logic [IW-1:0]     min_idx_reg;
    logic [IW-1:0]     sel_idx_reg;
    logic              rsp_valid_reg;
    logic              thr_reg;
    logic [SLOT_W-1:0] used_reg;

    logic              cmp_en;
    logic              cmp_slot_vld;
    logic              cmp_hit;
    logic              cmp_older;
    logic [IW-1:0]     chosen;
    logic              rd_en;
    logic [IW-1:0]     rd_idx;
    logic [TIME_W-1:0] elapsed;
    logic              restart;
    logic [CNT_W-1:0]  new_count;

    // scan compare on the registered read data
    assign cmp_en       = cmp_vld_reg && !match_reg;
    assign cmp_slot_vld = vld_reg[cmp_idx_reg];
    assign cmp_hit      = q_reg.addr == addr_reg;
    assign cmp_older    = !have_min_reg || (q_reg.start < min_start_reg);

    assign chosen = match_reg      ? match_idx_reg :
                    have_empty_reg ? empty_idx_reg : min_idx_reg;
    assign rd_en  = cmd.scan_rd || cmd.sel_rd;
    assign rd_idx = cmd.sel_rd ? chosen : scan_idx_reg;

    // read-modify-write of the chosen slot
    assign elapsed   = now_reg - q_reg.start;
    assign restart   = !vld_reg[sel_idx_reg] || (q_reg.addr != addr_reg) ||
                       (elapsed > TIME_W'(window_seconds));
    assign new_count = restart ? CNT_W'(1) :
                       (q_reg.count == CNT_MAX) ? CNT_MAX : q_reg.count + CNT_W'(1);

    always_comb
    begin
        wr_slot.addr  = addr_reg;
        wr_slot.start = restart ? now_reg : q_reg.start;
        wr_slot.count = new_count;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            mem[sel_idx_reg] <= wr_slot;
        end
        if (rd_en)
        begin
            q_reg <= mem[rd_idx];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_idx_reg   <= '0;
            cmp_vld_reg    <= 1'b0;
            vld_reg        <= '0;
            match_reg      <= 1'b0;
            have_empty_reg <= 1'b0;
            have_min_reg   <= 1'b0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.capture)
            begin
                scan_idx_reg   <= '0;
                cmp_vld_reg    <= 1'b0;
                match_reg      <= 1'b0;
                have_empty_reg <= 1'b0;
                have_min_reg   <= 1'b0;
            end
            else
            begin
                cmp_vld_reg <= cmd.scan_rd;
                if (cmd.scan_rd)
                begin
                    scan_idx_reg <= scan_idx_reg + IW'(1);
                end
                if (cmp_en)
                begin
                    if (cmp_slot_vld)
                    begin
                        if (cmp_hit)
                        begin
                            match_reg <= 1'b1;
                        end
                        else if (cmp_older)
                        begin
                            have_min_reg <= 1'b1;
                        end
                    end
                    else
                    begin
                        have_empty_reg <= 1'b1;
                    end
                end
            end
            if (cmd.commit)
            begin
                vld_reg[sel_idx_reg] <= 1'b1;
                rsp_valid_reg        <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            addr_reg <= source_address;
            now_reg  <= now_seconds;
        end
        cmp_idx_reg <= scan_idx_reg;
        if (cmp_en)
        begin
            if (cmp_slot_vld)
            begin
                if (cmp_hit)
                begin
                    match_idx_reg <= cmp_idx_reg;
                end
                else if (cmp_older)
                begin
                    min_start_reg <= q_reg.start;
                    min_idx_reg   <= cmp_idx_reg;
                end
            end
            else
            begin
                empty_idx_reg <= cmp_idx_reg;
            end
        end
        if (cmd.sel_rd)
        begin
            sel_idx_reg <= chosen;
        end
        if (cmd.commit)
        begin
            thr_reg  <= new_count > max_checks;
            used_reg <= SLOT_W'(sel_idx_reg);
        end
    end

    assign sts.scan_last = scan_idx_reg == LAST_IDX;
    assign sts.match     = match_reg;
    assign sts.out_busy  = rsp_valid_reg && !rsp_ready;

    assign rsp_valid = rsp_valid_reg;
    assign throttled = thr_reg;
    assign slot_used = used_reg;

endmodule

`default_nettype wire

### rtl/per_source_rate_limit_table_unit.sv
// ----------------------------------------------------------------------------
// per_source_rate_limit_table_unit
// fixed-window rate limiter keyed by ipv4 source address
// ----------------------------------------------------------------------------
// req carries source_address and now_seconds; rsp returns throttled and the
// table slot used, one response per request, in request order.
// window_seconds (0x0) and max_checks (0x4) are written over apb; the user must
// write them only while idle, which the block itself does not enforce.
// a request walks the table one slot a cycle through the single read port of
// the slot memory, stopping early on an address match, then reads and
// rewrites the chosen slot.
// a new request is taken only after the previous result is loaded into the
// response register.
// the response register frees the scan for the next request; only when a
// finished result still waits on rsp.ready does the update stall.
// reset empties all slots and restores window_seconds 10, max_checks 3.
// ----------------------------------------------------------------------------
`default_nettype none
`include "per_source_rate_limit_table_unit_macros.svh"

module per_source_rate_limit_table_unit #(
    parameter int SLOTS = 24
) (
    input  logic                          clk,
    input  logic                          rst_n,
    psrl_req_if.sink                      req,
    psrl_rsp_if.source                    rsp,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [psrl_pkg::PADDR_W-1:0]  paddr,
    input  logic [psrl_pkg::PDATA_W-1:0]  pwdata,
    output logic [psrl_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);
    import psrl_pkg::*;

    cmd_t             dp_cmd;
    sts_t             dp_sts;
    logic [WIN_W-1:0] window_seconds;
    logic [CNT_W-1:0] max_checks;

    psrl_regs u_regs (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .window_seconds (window_seconds),
        .max_checks     (max_checks)
    );

    psrl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .sts       (dp_sts),
        .cmd       (dp_cmd)
    );

    psrl_dp #(
        .SLOTS (SLOTS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (dp_cmd),
        .sts            (dp_sts),
        .source_address (req.source_address),
        .now_seconds    (req.now_seconds),
        .window_seconds (window_seconds),
        .max_checks     (max_checks),
        .rsp_ready      (rsp.ready),
        .rsp_valid      (rsp.valid),
        .throttled      (rsp.throttled),
        .slot_used      (rsp.slot_used)
    );

    `PSRL_ASSERT_IMP(a_no_overwrite, dp_cmd.commit, !(rsp.valid && !rsp.ready), "result overwritten while stalled")
    `PSRL_ASSERT_NXT(a_scan_follows, req.valid && req.ready, dp_cmd.scan_rd, "scan did not start after request")
    `PSRL_ASSERT_NXT(a_rsp_follows, dp_cmd.commit, rsp.valid, "response missing after slot update")

endmodule

`default_nettype wire
